[hdl/mips_ie_pkg.sv]
// ----------------------------------------------------------------------------
// mips_ie_pkg : shared definitions for the MIPS I-type execute block
// Opcodes, field widths and the record that travels between the execute
// stage and the memory-return stage.
// ----------------------------------------------------------------------------
package mips_ie_pkg;

   localparam int unsigned XLEN          = 32;
   localparam int unsigned RF_AW         = 5;
   localparam int unsigned OP_W          = 6;
   localparam int unsigned WORD_BYTES    = 4;
   localparam int unsigned MEM_BYTES_DEF = 4096;

   localparam logic [OP_W-1:0] OP_REGIMM = 6'h01;
   localparam logic [OP_W-1:0] OP_BEQ    = 6'h04;
   localparam logic [OP_W-1:0] OP_BNE    = 6'h05;
   localparam logic [OP_W-1:0] OP_BLEZ   = 6'h06;
   localparam logic [OP_W-1:0] OP_ADDIU  = 6'h09;
   localparam logic [OP_W-1:0] OP_ANDI   = 6'h0C;
   localparam logic [OP_W-1:0] OP_ORI    = 6'h0D;
   localparam logic [OP_W-1:0] OP_LUI    = 6'h0F;
   localparam logic [OP_W-1:0] OP_LB     = 6'h20;
   localparam logic [OP_W-1:0] OP_LW     = 6'h23;
   localparam logic [OP_W-1:0] OP_SB     = 6'h28;
   localparam logic [OP_W-1:0] OP_SW     = 6'h2B;

   // The only REGIMM rt code that is supported (bgez).
   localparam logic [RF_AW-1:0] RT_BGEZ  = 5'd1;

   // Outcome of the execute stage, held while the load data comes back.
   typedef struct packed {
      logic [XLEN-1:0]  next_pc;
      logic             taken;
      logic             wr;
      logic             ld_w;
      logic             ld_b;
      logic             bad;
      logic [RF_AW-1:0] rt;
      logic [XLEN-1:0]  val;
      logic [1:0]       lo;
   } exe_type;

endpackage

[hdl/mips_itype_execute.sv]
// ----------------------------------------------------------------------------
// mips_itype_execute : executes MIPS I-type instruction words
// Keeps a program counter, a 32-entry register file and a byte-addressed,
// little-endian data memory, and returns one result beat per instruction.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Payload
//  -------  ---------  ---------------------  -----------------------------------
//  csr_     in         csr_wr_en              csr_wr_data (start_pc)
//  req_     in         req_valid / req_stall  req_instruction
//  rsp_     out        rsp_valid / rsp_stall  rsp_next_pc, rsp_branch_taken,
//                                             rsp_reg_written, rsp_dest_index,
//                                             rsp_dest_value, rsp_bad_opcode
//
//  One instruction beat can be accepted every cycle while req_stall is low;
//  each beat passes the register file read at the accepting edge into S1,
//  then execute with data memory access into S2, then load return into
//  the output register, where its result beat appears.
//  After reset the data memory is cleared one row of four bytes a cycle, over
//  all MEM_BYTES/4 rows; req_stall stays high meanwhile, while csr writes
//  are taken as usual. Reset is synchronous and active high.
//  A stalled result holds the output register; the stages behind it keep
//  filling until they are full, and only then is req_stall raised.
//
// MEM_BYTES must be a power of two, so that addresses wrap by masking and the
// four bytes of a word always fall in four different banks.

module mips_itype_execute #(
   parameter int unsigned MEM_BYTES = mips_ie_pkg::MEM_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_wr_en,
   input  logic [mips_ie_pkg::XLEN-1:0]         csr_wr_data,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mips_ie_pkg::XLEN-1:0]         req_instruction,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mips_ie_pkg::XLEN-1:0]         rsp_next_pc,
   output logic                                 rsp_branch_taken,
   output logic                                 rsp_reg_written,
   output logic [mips_ie_pkg::RF_AW-1:0]        rsp_dest_index,
   output logic [mips_ie_pkg::XLEN-1:0]         rsp_dest_value,
   output logic                                 rsp_bad_opcode
);

   localparam int unsigned XLEN   = mips_ie_pkg::XLEN;
   localparam int unsigned RF_AW  = mips_ie_pkg::RF_AW;
   localparam int unsigned NBANK  = mips_ie_pkg::WORD_BYTES;
   localparam int unsigned MEM_AW = $clog2(MEM_BYTES);
   localparam int unsigned ROW_AW = MEM_AW - 2;
   localparam int unsigned ROWS   = MEM_BYTES / NBANK;
   localparam int unsigned RF_N   = 2 ** RF_AW;

   // ------------------------------------------------------------------------
   // Beat flow. Three stages: S1 holds the instruction and its register file
   // read data, S2 holds the execute outcome and the data memory read data,
   // and the output register holds the finished result.
   // ------------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, s2_free, s1_free;
   logic req_acc, s1_adv, s2_adv;

   // Clearing pass over the data memory rows after reset.
   logic              clr_ff, clr_in;
   logic [ROW_AW-1:0] clr_row_ff, clr_row_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = clr_ff || !s1_free;
   assign req_acc   = req_valid && !req_stall;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign s2_adv    = s2_valid_ff && out_free;

   always_comb begin
      s1_valid_in  = req_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);
      rsp_valid_in = s2_adv ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_row_in = clr_row_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + ROW_AW'(1);
         if (clr_row_ff == ROW_AW'(ROWS - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b1;
         clr_row_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         clr_row_ff   <= clr_row_in;
      end
   end

   // ------------------------------------------------------------------------
   // Program counter, loaded directly by csr writes; user keeps the block idle.
   // ------------------------------------------------------------------------
   logic [XLEN-1:0]       pc_ff, pc_in;
   mips_ie_pkg::exe_type  exe_in;

   always_comb begin
      if (csr_wr_en) begin
         pc_in = csr_wr_data;
      end else if (s1_adv) begin
         pc_in = exe_in.next_pc;
      end else begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // ------------------------------------------------------------------------
   // Register file: a two-read, one-write memory read at acceptance. Entries
   // that were never written read as zero through their valid bits; register
   // zero is never written, so it always reads as zero.
   // The write of the instruction in S2 lands when it leaves S2. A write at
   // the very edge of the read is caught by the bypass flags, and a write
   // still pending in S2 is forwarded into the execute stage.
   // ------------------------------------------------------------------------
   logic [XLEN-1:0]  rf_mem [RF_N];
   logic [RF_N-1:0]  rf_vld_ff, rf_vld_in;
   logic             rf_we;
   logic [RF_AW-1:0] rf_wa;
   logic [XLEN-1:0]  rf_wd;
   logic [RF_AW-1:0] rd_rs, rd_rt;

   logic [XLEN-1:0]  rf_a_q_ff, rf_b_q_ff, byp_data_ff;
   logic             a_vld_ff, b_vld_ff, a_byp_ff, b_byp_ff;
   logic [XLEN-1:0]  s1_instr_ff;

   mips_ie_pkg::exe_type s2_ff;
   logic [XLEN-1:0]      s2_wval;

   assign rd_rs = req_instruction[25:21];
   assign rd_rt = req_instruction[20:16];
   assign rf_we = s2_adv && s2_ff.wr;
   assign rf_wa = s2_ff.rt;
   assign rf_wd = s2_wval;

   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (rf_we) begin
         rf_vld_in[rf_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else begin
         rf_vld_ff <= rf_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_wa] <= rf_wd;
      end
      if (req_acc) begin
         rf_a_q_ff <= rf_mem[rd_rs];
         rf_b_q_ff <= rf_mem[rd_rt];
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_instr_ff <= req_instruction;
         a_vld_ff    <= rf_vld_ff[rd_rs];
         b_vld_ff    <= rf_vld_ff[rd_rt];
         a_byp_ff    <= rf_we && (rf_wa == rd_rs);
         b_byp_ff    <= rf_we && (rf_wa == rd_rt);
         byp_data_ff <= rf_wd;
      end
   end

   // ------------------------------------------------------------------------
   // Execute stage (S1).
   // ------------------------------------------------------------------------
   logic [mips_ie_pkg::OP_W-1:0] op;
   logic [RF_AW-1:0]             rs, rt;
   logic [15:0]                  imm;
   logic [XLEN-1:0]              simm, opa, opb, seq, target, addr;
   logic                         writes, taken, bad, ld_w, ld_b, st_w, st_b;
   logic [XLEN-1:0]              val;

   assign op   = s1_instr_ff[31:26];
   assign rs   = s1_instr_ff[25:21];
   assign rt   = s1_instr_ff[20:16];
   assign imm  = s1_instr_ff[15:0];
   assign simm = {{16{imm[15]}}, imm};

   always_comb begin
      if (s2_valid_ff && s2_ff.wr && (s2_ff.rt == rs)) begin
         opa = s2_wval;
      end else if (a_byp_ff) begin
         opa = byp_data_ff;
      end else if (a_vld_ff) begin
         opa = rf_a_q_ff;
      end else begin
         opa = '0;
      end
      if (s2_valid_ff && s2_ff.wr && (s2_ff.rt == rt)) begin
         opb = s2_wval;
      end else if (b_byp_ff) begin
         opb = byp_data_ff;
      end else if (b_vld_ff) begin
         opb = rf_b_q_ff;
      end else begin
         opb = '0;
      end
   end

   assign seq    = pc_ff + XLEN'(4);
   assign target = seq + {simm[XLEN-3:0], 2'b00};
   assign addr   = opa + simm;

   always_comb begin
      writes = 1'b0;
      taken  = 1'b0;
      bad    = 1'b0;
      ld_w   = 1'b0;
      ld_b   = 1'b0;
      st_w   = 1'b0;
      st_b   = 1'b0;
      val    = '0;
      unique case (op)
         mips_ie_pkg::OP_LUI: begin
            writes = 1'b1;
            val    = {imm, 16'h0000};
         end
         mips_ie_pkg::OP_ORI: begin
            writes = 1'b1;
            val    = opa | {16'h0000, imm};
         end
         mips_ie_pkg::OP_ANDI: begin
            writes = 1'b1;
            val    = opa & {16'h0000, imm};
         end
         mips_ie_pkg::OP_ADDIU: begin
            writes = 1'b1;
            val    = addr;
         end
         mips_ie_pkg::OP_BEQ: begin
            taken = (opa == opb);
         end
         mips_ie_pkg::OP_BNE: begin
            taken = (opa != opb);
         end
         mips_ie_pkg::OP_BLEZ: begin
            taken = opa[XLEN-1] || (opa == '0);
         end
         mips_ie_pkg::OP_REGIMM: begin
            if (rt == mips_ie_pkg::RT_BGEZ) begin
               taken = !opa[XLEN-1];
            end else begin
               bad = 1'b1;
            end
         end
         mips_ie_pkg::OP_LW: begin
            writes = 1'b1;
            ld_w   = 1'b1;
         end
         mips_ie_pkg::OP_LB: begin
            writes = 1'b1;
            ld_b   = 1'b1;
         end
         mips_ie_pkg::OP_SW: begin
            st_w = 1'b1;
         end
         mips_ie_pkg::OP_SB: begin
            st_b = 1'b1;
         end
         default: begin
            bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      exe_in.next_pc = taken ? target : seq;
      exe_in.taken   = taken;
      exe_in.wr      = writes && (rt != '0);
      exe_in.ld_w    = ld_w;
      exe_in.ld_b    = ld_b;
      exe_in.bad     = bad;
      exe_in.rt      = rt;
      exe_in.val     = val;
      exe_in.lo      = addr[1:0];
   end

   // ------------------------------------------------------------------------
   // Data memory: four byte-wide banks, bank = address bits [1:0]. A word
   // that starts past bank 0 spills into the next row for the lower banks,
   // wrapping at the end of memory. Reads and writes are issued as S1 moves
   // on, so a store is always visible to the next instruction's load.
   // ------------------------------------------------------------------------
   logic [ROW_AW-1:0] row_base;
   logic [7:0]        dm_q_ff [NBANK];

   assign row_base = addr[MEM_AW-1:2];

   for (genvar bk = 0; bk < NBANK; bk++) begin : g_bank
      logic [7:0]        mem [ROWS];
      logic [ROW_AW-1:0] row, wa;
      logic              we;
      logic [1:0]        lane;
      logic [7:0]        wd;

      always_comb begin
         row  = row_base + ROW_AW'((2'(bk) < addr[1:0]) ? 1 : 0);
         lane = 2'(bk) - addr[1:0];
         we   = clr_ff || (s1_adv && (st_w || (st_b && (addr[1:0] == 2'(bk)))));
         wa   = clr_ff ? clr_row_ff : row;
         if (clr_ff) begin
            wd = '0;
         end else if (st_b) begin
            wd = opb[7:0];
         end else begin
            wd = opb[{lane, 3'b000} +: 8];
         end
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[wa] <= wd;
         end
         if (s1_adv) begin
            dm_q_ff[bk] <= mem[row];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_ff <= exe_in;
      end
   end

   // ------------------------------------------------------------------------
   // Load return (S2): reassemble the word little-endian from the banks.
   // ------------------------------------------------------------------------
   logic [XLEN-1:0] ld_word;
   logic [7:0]      ld_byte;

   always_comb begin
      for (int i = 0; i < NBANK; i++) begin
         ld_word[8*i +: 8] = dm_q_ff[2'(s2_ff.lo + 2'(i))];
      end
      ld_byte = dm_q_ff[s2_ff.lo];
      if (s2_ff.ld_w) begin
         s2_wval = ld_word;
      end else if (s2_ff.ld_b) begin
         s2_wval = {{(XLEN-8){ld_byte[7]}}, ld_byte};
      end else begin
         s2_wval = s2_ff.val;
      end
   end

   // ------------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------------
   logic [XLEN-1:0]  next_pc_ff, dest_value_ff;
   logic [RF_AW-1:0] dest_index_ff;
   logic             taken_ff, written_ff, bad_ff;

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         next_pc_ff    <= s2_ff.next_pc;
         taken_ff      <= s2_ff.taken;
         written_ff    <= s2_ff.wr;
         dest_index_ff <= s2_ff.wr ? s2_ff.rt : '0;
         dest_value_ff <= s2_ff.wr ? s2_wval : '0;
         bad_ff        <= s2_ff.bad;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = next_pc_ff;
   assign rsp_branch_taken = taken_ff;
   assign rsp_reg_written  = written_ff;
   assign rsp_dest_index   = dest_index_ff;
   assign rsp_dest_value   = dest_value_ff;
   assign rsp_bad_opcode   = bad_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for mips_itype_execute
// Feeds instruction words through the request channel. Each accepted word is
// executed on a local copy of the program counter, register file and data
// memory, and the resulting beat is compared field by field with the block.
// A short scripted sequence comes first. Random programs then run under
// several start_pc settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------

module tb;

   localparam int unsigned XLEN       = mips_ie_pkg::XLEN;
   localparam int unsigned RF_AW      = mips_ie_pkg::RF_AW;
   localparam int unsigned OP_W       = mips_ie_pkg::OP_W;
   localparam int unsigned WORD_BYTES = mips_ie_pkg::WORD_BYTES;
   localparam int unsigned MEM_BYTES  = mips_ie_pkg::MEM_BYTES_DEF;

   // The block clears its data memory a row of four bytes per cycle after
   // reset and holds req_stall meanwhile. That is the longest stretch without
   // any beat in a correct run, so the watchdog allows several times that.
   localparam int STUCK_LIMIT     = 4 * (MEM_BYTES / WORD_BYTES) + 400;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int NUM_PHASES      = 5;
   localparam int SCRIPT_ROWS     = 26;

   // REGIMM rt code for bltz, which the block does not support.
   localparam logic [RF_AW-1:0] RT_BLTZ = 5'd0;

   localparam logic [OP_W-1:0] SUPPORTED_OPS [12] = '{
      mips_ie_pkg::OP_LUI, mips_ie_pkg::OP_ORI, mips_ie_pkg::OP_ANDI,
      mips_ie_pkg::OP_ADDIU, mips_ie_pkg::OP_BEQ, mips_ie_pkg::OP_BNE,
      mips_ie_pkg::OP_BLEZ, mips_ie_pkg::OP_REGIMM, mips_ie_pkg::OP_LW,
      mips_ie_pkg::OP_LB, mips_ie_pkg::OP_SW, mips_ie_pkg::OP_SB
   };

   // One result beat as the block presents it.
   typedef struct packed {
      logic [XLEN-1:0]  next_pc;
      logic             taken;
      logic             wr;
      logic [RF_AW-1:0] idx;
      logic [XLEN-1:0]  val;
      logic             bad;
   } outcome_type;

   // A scripted instruction. Where has_want is set, the result beat is the one
   // typed into the row; otherwise the local executor supplies it.
   typedef struct packed {
      logic [XLEN-1:0] word;
      logic            has_want;
      outcome_type     want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [XLEN-1:0]      csr_wr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [XLEN-1:0]      req_instruction;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [XLEN-1:0]      rsp_next_pc;
   logic                 rsp_branch_taken;
   logic                 rsp_reg_written;
   logic [RF_AW-1:0]     rsp_dest_index;
   logic [XLEN-1:0]      rsp_dest_value;
   logic                 rsp_bad_opcode;

   // Local architectural state, kept in step with every accepted beat.
   logic [XLEN-1:0]      pc_model;
   logic [XLEN-1:0]      gpr [32];
   logic [7:0]           mem_model [MEM_BYTES];

   outcome_type          pending_results [$];
   outcome_type          arrived;
   script_row_type       script [SCRIPT_ROWS];
   int unsigned          mismatches   = 0;
   int                   stuck_cycles = 0;
   bit                   calm         = 1'b0;

   always #5 clock = ~clock;

   mips_itype_execute #(
      .MEM_BYTES (MEM_BYTES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_instruction  (req_instruction),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_reg_written  (rsp_reg_written),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_dest_value   (rsp_dest_value),
      .rsp_bad_opcode   (rsp_bad_opcode)
   );

   // Executes one instruction word on the local state and returns the beat
   // that the block should produce for it. Register zero is never written, so
   // it always reads as zero.
   function automatic outcome_type execute_instr(input logic [XLEN-1:0] word);
      logic [OP_W-1:0]  op;
      logic [RF_AW-1:0] rs;
      logic [RF_AW-1:0] rt;
      logic [15:0]      imm;
      logic [XLEN-1:0]  simm;
      logic [XLEN-1:0]  a;
      logic [XLEN-1:0]  b;
      logic [XLEN-1:0]  seq;
      logic [XLEN-1:0]  target;
      logic [XLEN-1:0]  addr;
      logic [XLEN-1:0]  val;
      logic [7:0]       loaded;
      logic             wr;
      logic             taken;
      logic             bad;
      outcome_type      r;
      op     = word[31:26];
      rs     = word[25:21];
      rt     = word[20:16];
      imm    = word[15:0];
      simm   = {{16{imm[15]}}, imm};
      a      = gpr[rs];
      b      = gpr[rt];
      seq    = pc_model + 32'd4;
      target = seq + (simm << 2);
      addr   = a + simm;
      wr     = 1'b0;
      taken  = 1'b0;
      bad    = 1'b0;
      val    = '0;
      unique case (op)
         mips_ie_pkg::OP_LUI: begin
            wr  = 1'b1;
            val = {imm, 16'h0000};
         end
         mips_ie_pkg::OP_ORI: begin
            wr  = 1'b1;
            val = a | {16'h0000, imm};
         end
         mips_ie_pkg::OP_ANDI: begin
            wr  = 1'b1;
            val = a & {16'h0000, imm};
         end
         mips_ie_pkg::OP_ADDIU: begin
            wr  = 1'b1;
            val = a + simm;
         end
         mips_ie_pkg::OP_BEQ:  taken = (a == b);
         mips_ie_pkg::OP_BNE:  taken = (a != b);
         mips_ie_pkg::OP_BLEZ: taken = a[31] || (a == '0);
         mips_ie_pkg::OP_REGIMM: begin
            if (rt == mips_ie_pkg::RT_BGEZ) begin
               taken = !a[31];
            end else begin
               bad = 1'b1;
            end
         end
         mips_ie_pkg::OP_LW: begin
            // Little-endian; each byte wraps round the end of memory alone.
            wr = 1'b1;
            for (int unsigned k = 0; k < WORD_BYTES; k++) begin
               val[8*k +: 8] = mem_model[(addr + k) % MEM_BYTES];
            end
         end
         mips_ie_pkg::OP_LB: begin
            wr     = 1'b1;
            loaded = mem_model[addr % MEM_BYTES];
            val    = {{24{loaded[7]}}, loaded};
         end
         mips_ie_pkg::OP_SW: begin
            for (int unsigned k = 0; k < WORD_BYTES; k++) begin
               mem_model[(addr + k) % MEM_BYTES] = b[8*k +: 8];
            end
         end
         mips_ie_pkg::OP_SB:   mem_model[addr % MEM_BYTES] = b[7:0];
         default: bad = 1'b1;
      endcase
      if (wr && rt != '0) begin
         gpr[rt] = val;
      end else begin
         wr = 1'b0;
      end
      pc_model  = taken ? target : seq;
      r.next_pc = pc_model;
      r.taken   = taken;
      r.wr      = wr;
      r.idx     = wr ? rt : '0;
      r.val     = wr ? val : '0;
      r.bad     = bad;
      return r;
   endfunction

   // Mostly well-formed instructions with random operands. Loads and stores
   // are steered towards a small window at either end of memory so that they
   // meet data written earlier; a tenth of the words are plain noise.
   function automatic logic [XLEN-1:0] random_instr();
      logic [OP_W-1:0]  op;
      logic [RF_AW-1:0] rs;
      logic [RF_AW-1:0] rt;
      logic [15:0]      imm;
      if ($urandom_range(0, 9) == 0) begin
         return $urandom();
      end
      op  = SUPPORTED_OPS[$urandom_range(0, 11)];
      rs  = RF_AW'($urandom_range(0, 31));
      rt  = RF_AW'($urandom_range(0, 31));
      imm = 16'($urandom());
      unique case (op)
         mips_ie_pkg::OP_REGIMM: begin
            if ($urandom_range(0, 3) != 0) begin
               rt = mips_ie_pkg::RT_BGEZ;
            end
         end
         mips_ie_pkg::OP_BEQ, mips_ie_pkg::OP_BNE: begin
            if ($urandom_range(0, 2) == 0) begin
               rt = rs;
            end
         end
         mips_ie_pkg::OP_LW, mips_ie_pkg::OP_LB,
         mips_ie_pkg::OP_SW, mips_ie_pkg::OP_SB: begin
            if ($urandom_range(0, 2) != 0) begin
               rs  = '0;
               imm = ($urandom_range(0, 3) == 0)
                     ? 16'hFFF0 + 16'($urandom_range(0, 15))
                     : 16'($urandom_range(0, 63));
            end
         end
         default: ;
      endcase
      return {op, rs, rt, imm};
   endfunction

   // Presents one instruction beat, entered and left at a falling edge. The
   // expected result is queued at the rising edge that accepts the beat.
   task automatic issue_instr(input logic [XLEN-1:0] word, input logic has_want,
                              input outcome_type want);
      int          gap;
      outcome_type got;
      gap = calm ? 0 : int'($urandom_range(0, 8));
      if (gap != 0) begin
         req_valid       = 1'b0;
         req_instruction = $urandom();
         repeat (gap) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_instruction = word;
      do @(posedge clock); while (req_stall);
      got = execute_instr(word);
      pending_results.push_back(has_want ? want : got);
      @(negedge clock);
   endtask

   // Stops sending and waits at falling edges until every result is back,
   // which leaves the block empty.
   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Writes start_pc; the block loads it into the program counter at once.
   task automatic write_start_pc(input logic [XLEN-1:0] value);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(posedge clock);
      pc_model = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic check_field(input string label, input logic [XLEN-1:0] want,
                              input logic [XLEN-1:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %h, actual %h", $time, label, want, got);
      end
   endtask

   // Result side: each accepted beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t ns: result beat expected none, actual next_pc %h",
                     $time, rsp_next_pc);
         end else begin
            arrived = pending_results.pop_front();
            check_field("next_pc", arrived.next_pc, rsp_next_pc);
            check_field("branch_taken", XLEN'(arrived.taken), XLEN'(rsp_branch_taken));
            check_field("reg_written", XLEN'(arrived.wr), XLEN'(rsp_reg_written));
            check_field("dest_index", XLEN'(arrived.idx), XLEN'(rsp_dest_index));
            check_field("dest_value", arrived.val, rsp_dest_value);
            check_field("bad_opcode", XLEN'(arrived.bad), XLEN'(rsp_bad_opcode));
         end
      end
   end

   // Watchdog: a run that makes no progress for too long has hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("mips_itype_execute verification failed");
         $finish;
      end
   end

   // Result side back-pressure: a random stall before each result beat, none
   // at all while the calm phase runs.
   initial begin : rsp_pacing
      int hold;
      rsp_stall = 1'b1;
      forever begin
         hold      = calm ? 0 : int'($urandom_range(0, 8));
         rsp_stall = (hold != 0);
         repeat (hold) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic [XLEN-1:0] start_value;
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_valid       = 1'b0;
      req_instruction = '0;
      pc_model        = '0;
      foreach (gpr[k]) gpr[k] = '0;
      foreach (mem_model[k]) mem_model[k] = '0;

      // Scripted sequence, run from the reset value of start_pc (zero). The
      // first rows are easy to follow by hand, so their beats are typed in:
      // unknown opcodes, immediates at their extremes, an add that wraps and
      // writes to register zero being dropped. A word store at the very top
      // of memory wraps its bytes round to address zero; the loads after it
      // read those bytes back, and sign-extend a byte. Every branch is then
      // taken and not taken at least once each, with offsets at both extremes;
      // blez ignores its rt field.
      script = '{
         '{32'hFFFF_FFFF, 1'b1, '{32'd4,  1'b0, 1'b0, 5'd0, 32'h0, 1'b1}},
         '{{mips_ie_pkg::OP_REGIMM, 5'd0, RT_BLTZ, 16'h0000}, 1'b1,
           '{32'd8, 1'b0, 1'b0, 5'd0, 32'h0, 1'b1}},
         '{32'h0000_0000, 1'b1, '{32'd12, 1'b0, 1'b0, 5'd0, 32'h0, 1'b1}},
         '{{mips_ie_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF}, 1'b1,
           '{32'd16, 1'b0, 1'b1, 5'd1, 32'hFFFF_0000, 1'b0}},
         '{{mips_ie_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF}, 1'b1,
           '{32'd20, 1'b0, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0}},
         '{{mips_ie_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h7FFF}, 1'b1,
           '{32'd24, 1'b0, 1'b1, 5'd2, 32'h0000_7FFF, 1'b0}},
         '{{mips_ie_pkg::OP_ADDIU, 5'd1, 5'd3, 16'h0001}, 1'b1,
           '{32'd28, 1'b0, 1'b1, 5'd3, 32'h0, 1'b0}},
         '{{mips_ie_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h0005}, 1'b1,
           '{32'd32, 1'b0, 1'b0, 5'd0, 32'h0, 1'b0}},
         '{{mips_ie_pkg::OP_ANDI, 5'd1, 5'd4, 16'h8000}, 1'b1,
           '{32'd36, 1'b0, 1'b1, 5'd4, 32'h0000_8000, 1'b0}},
         '{{mips_ie_pkg::OP_LUI, 5'd0, 5'd0, 16'h1234}, 1'b1,
           '{32'd40, 1'b0, 1'b0, 5'd0, 32'h0, 1'b0}},
         '{{mips_ie_pkg::OP_SW, 5'd0, 5'd1, 16'hFFFF}, 1'b1,
           '{32'd44, 1'b0, 1'b0, 5'd0, 32'h0, 1'b0}},
         '{{mips_ie_pkg::OP_LW, 5'd0, 5'd5, 16'h0000}, 1'b0, '0},
         '{{mips_ie_pkg::OP_LB, 5'd0, 5'd6, 16'hFFFF}, 1'b0, '0},
         '{{mips_ie_pkg::OP_SB, 5'd0, 5'd2, 16'h0010}, 1'b0, '0},
         '{{mips_ie_pkg::OP_LB, 5'd0, 5'd7, 16'h0010}, 1'b0, '0},
         '{{mips_ie_pkg::OP_SW, 5'd0, 5'd4, 16'h0020}, 1'b0, '0},
         '{{mips_ie_pkg::OP_LB, 5'd0, 5'd8, 16'h0021}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BEQ, 5'd1, 5'd1, 16'h7FFF}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0000}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BNE, 5'd1, 5'd2, 16'h8000}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BNE, 5'd3, 5'd0, 16'h0001}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BLEZ, 5'd0, 5'd31, 16'hFFFF}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BLEZ, 5'd1, 5'd0, 16'h0004}, 1'b0, '0},
         '{{mips_ie_pkg::OP_BLEZ, 5'd2, 5'd0, 16'h0004}, 1'b0, '0},
         '{{mips_ie_pkg::OP_REGIMM, 5'd2, mips_ie_pkg::RT_BGEZ, 16'h0004}, 1'b0, '0},
         '{{mips_ie_pkg::OP_REGIMM, 5'd1, mips_ie_pkg::RT_BGEZ, 16'h0004}, 1'b0, '0}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The block holds req_stall while it clears memory; the first beat
      // simply waits for it.
      for (int k = 0; k < SCRIPT_ROWS; k++) begin
         issue_instr(script[k].word, script[k].has_want, script[k].want);
      end

      // Random programs, each started from a fresh start_pc once the block
      // has gone quiet. The register file and memory carry over between
      // phases. The third phase runs with no gaps and no stalls at all.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         unique case (phase)
            0:       start_value = 32'hFFFF_FFFC;
            1:       start_value = 32'hFFFF_FFFF;
            2:       start_value = $urandom();
            3:       start_value = 32'h0040_0000;
            default: start_value = 32'h0000_0000;
         endcase
         write_start_pc(start_value);
         calm = (phase == 2);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Half-way through the first phase the sender holds off until
            // every outstanding result has come back.
            if (phase == 0 && n == ITEMS_PER_PHASE / 2) begin
               drain_results();
            end
            issue_instr(random_instr(), 1'b0, '0);
         end
      end
      calm = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("mips_itype_execute verification clean");
      end else begin
         $display("mips_itype_execute verification failed");
      end
      $finish;
   end

endmodule
